/* rtl/lftd_pkg.sv */
package lftd_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int IV_W    = 12;
    localparam int TH_W    = 12;
    localparam int BC_W    = 11;
    localparam int KIND_W  = 2;
    localparam int CAUSE_W = 2;
    localparam int ERR_W   = 8;
    localparam int MODE_W  = 2;
    localparam int SOFL_W  = 3;
    localparam int BYTES_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int MAX_BITS   = 3;

    // Parameter defaults
    localparam int INTERVAL_WIDTH_DEF = 12;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_ARM     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_BIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

    // End causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_ERRORS  = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_FULL    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODING_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOF_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_TH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THREE_TH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_TH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_BYTES   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT   = 3'd7;

    // Coding mode bits: bit 0 double speed, bit 1 Manchester
    localparam int MODE_DOUBLE_BIT = 0;
    localparam int MODE_MANCH_BIT  = 1;

    // Register reset values
    localparam logic [MODE_W-1:0]  RST_CODING_MODE = 2'd0;
    localparam logic [SOFL_W-1:0]  RST_SOF_LENGTH  = 3'd1;
    localparam logic [TH_W-1:0]    RST_START_TH    = 12'd199;
    localparam logic [TH_W-1:0]    RST_TWO_TH      = 12'd25;
    localparam logic [TH_W-1:0]    RST_THREE_TH    = 12'd41;
    localparam logic [TH_W-1:0]    RST_FOUR_TH     = 12'd57;
    localparam logic [BYTES_W-1:0] RST_BUF_BYTES   = 8'd64;
    localparam logic [ERR_W-1:0]   RST_ERR_LIMIT   = 8'd100;

    // Start-of-frame handling
    localparam logic [7:0]        SOF_FIRST_BIT    = 8'h80;
    localparam logic [7:0]        SOF3_MASK        = 8'hE0;
    localparam logic [7:0]        SOF3_PATTERN     = 8'hC0;
    localparam logic [SOFL_W-1:0] SOF_FALLBACK_LEN = 3'd4;
    localparam logic [SOFL_W-1:0] SOF_SHORT_LEN    = 3'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  coding_mode;
        logic [SOFL_W-1:0]  sof_length;
        logic [TH_W-1:0]    start_th;
        logic [TH_W-1:0]    two_th;
        logic [TH_W-1:0]    three_th;
        logic [TH_W-1:0]    four_th;
        logic [BYTES_W-1:0] buffer_bytes;
        logic [ERR_W-1:0]   error_limit;
    } t_cfg;

    // All results one input causes: optional start, up to three data bits
    // with consecutive indexes, optional end.
    typedef struct packed {
        logic                start;
        logic [1:0]          nbits;
        logic [MAX_BITS-1:0] bits;
        logic [BC_W-1:0]     base_idx;
        logic                end_en;
        logic [CAUSE_W-1:0]  cause;
        logic [BC_W-1:0]     end_idx;
        logic                sof_ok;
        logic [ERR_W-1:0]    err;
    } t_rec;

endpackage

/* rtl/lftd_front.sv */
module lftd_front #(
    parameter int INTERVAL_WIDTH = lftd_pkg::INTERVAL_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lftd_pkg::t_cfg             i_cfg,
    input  logic                       i_valid,
    input  logic [lftd_pkg::CMD_W-1:0] i_cmd,
    input  logic [lftd_pkg::IV_W-1:0]  i_interval,
    output logic                       o_stall,
    input  logic                       i_full,
    output logic                       o_push,
    output lftd_pkg::t_rec             o_rec
);
    import lftd_pkg::*;

    localparam int USED_W = (INTERVAL_WIDTH < IV_W) ? INTERVAL_WIDTH : IV_W;
    localparam logic [IV_W-1:0] IV_MASK = IV_W'((32'd1 << USED_W) - 32'd1);

    logic              r_started, n_started;
    logic              r_done, n_done;
    logic              r_prev, n_prev;
    logic              r_skip, n_skip;
    logic              r_sof_done, n_sof_done;
    logic              r_good, n_good;
    logic [7:0]        r_shift, n_shift;
    logic [BC_W-1:0]   r_bc, n_bc;
    logic [ERR_W-1:0]  r_reject, n_reject;
    logic [SOFL_W-1:0] r_sof_eff, n_sof_eff;

    logic [IV_W-1:0] rb;
    logic [TH_W-1:0] t2, t3, t4;
    logic            ds, manch;
    logic [1:0]      dec_n;
    logic [1:0]      dec_b;
    logic            dec_rej, dec_prev, dec_skip;
    logic            accept;
    t_rec            rec;

    assign rb     = i_interval & IV_MASK;
    assign ds     = i_cfg.coding_mode[MODE_DOUBLE_BIT];
    assign manch  = i_cfg.coding_mode[MODE_MANCH_BIT];
    assign t2     = i_cfg.two_th >> ds;
    assign t3     = i_cfg.three_th >> ds;
    assign t4     = i_cfg.four_th >> ds;
    assign accept = i_valid && !i_full;

    // Interval classification; dec_b[0] is the first bit out
    always_comb begin
        dec_n    = 2'd0;
        dec_b    = 2'b00;
        dec_rej  = 1'b0;
        dec_prev = r_prev;
        dec_skip = r_skip;
        if (!manch) begin
            if (rb >= t4) begin
                dec_prev = 1'b0;
                dec_n    = 2'd1;
            end else if (rb >= t3) begin
                dec_prev = !r_prev;
                dec_n    = 2'd1;
                dec_b[0] = !r_prev;
                dec_skip = !r_prev;
            end else if (rb >= t2) begin
                if (!r_skip) begin
                    dec_prev = 1'b1;
                    dec_n    = 2'd1;
                    dec_b[0] = 1'b1;
                end
                dec_skip = !r_skip;
            end else begin
                dec_rej = 1'b1;
            end
        end else begin
            if (rb >= t4) begin
                dec_n = 2'd2;
                dec_b = 2'b10;
            end else if (rb >= t3) begin
                if (!r_skip) begin
                    dec_n = 2'd2;
                    dec_b = 2'b10;
                end else begin
                    dec_n = 2'd1;
                end
                dec_prev = !r_prev;
                dec_skip = !r_skip;
            end else if (rb >= t2) begin
                dec_n    = 2'd1;
                dec_b[0] = r_prev;
            end else begin
                dec_rej = 1'b1;
            end
        end
    end

    always_comb begin
        logic [7:0]        shift2;
        logic [7:0]        mask;
        logic [BC_W-1:0]   bc2;
        logic [BC_W-1:0]   held;
        logic [BC_W-1:0]   pj;
        logic [SOFL_W-1:0] s;
        logic [3:0]        p;
        logic              good;

        n_started  = r_started;
        n_done     = r_done;
        n_prev     = r_prev;
        n_skip     = r_skip;
        n_sof_done = r_sof_done;
        n_good     = r_good;
        n_shift    = r_shift;
        n_bc       = r_bc;
        n_reject   = r_reject;
        n_sof_eff  = r_sof_eff;
        rec        = '0;
        shift2     = r_shift;
        mask       = 8'h00;
        bc2        = r_bc;
        held       = '0;
        pj         = '0;
        s          = r_sof_eff;
        p          = '0;
        good       = 1'b0;

        if (accept) begin
            case (i_cmd)
                CMD_ARM: begin
                    n_started  = 1'b0;
                    n_done     = 1'b0;
                    n_prev     = 1'b1;
                    n_skip     = 1'b1;
                    n_sof_done = 1'b0;
                    n_good     = 1'b0;
                    n_shift    = 8'h00;
                    n_bc       = '0;
                    n_reject   = '0;
                    n_sof_eff  = i_cfg.sof_length;
                end
                CMD_TIMEOUT: begin
                    if (!r_done) begin
                        n_done     = 1'b1;
                        rec.end_en = 1'b1;
                        rec.cause  = CAUSE_TIMEOUT;
                    end
                end
                CMD_EDGE: begin
                    if (!r_done) begin
                        if (!r_started) begin
                            if (rb >= i_cfg.start_th) begin
                                n_started = 1'b1;
                                n_shift   = SOF_FIRST_BIT;
                                n_bc      = BC_W'(1);
                                rec.start = 1'b1;
                            end else if (r_reject != '1) begin
                                n_reject = r_reject + 1'b1;
                            end
                        end else begin
                            if (dec_rej && (r_reject != '1)) begin
                                n_reject = r_reject + 1'b1;
                            end
                            n_prev = dec_prev;
                            n_skip = dec_skip;
                            if (r_sof_done) begin
                                rec.nbits    = dec_n;
                                rec.bits     = {1'b0, dec_b};
                                rec.base_idx = r_bc;
                                n_bc         = r_bc + BC_W'(dec_n);
                            end else begin
                                // bits still belong to the start of frame: hold them
                                for (int j = 0; j < 2; j++) begin
                                    pj = r_bc + BC_W'(j);
                                    if ((2'(j) < dec_n) && dec_b[j] && (pj < BC_W'(8))) begin
                                        shift2[~pj[2:0]] = 1'b1;
                                    end
                                end
                                bc2     = r_bc + BC_W'(dec_n);
                                n_shift = shift2;
                                n_bc    = bc2;
                                if (bc2 >= BC_W'(r_sof_eff)) begin
                                    mask = ~(8'hFF >> r_sof_eff);
                                    good = (shift2 & mask) == mask;
                                    if (!good && (r_sof_eff == SOF_FALLBACK_LEN)) begin
                                        s    = SOF_SHORT_LEN;
                                        good = (shift2 & SOF3_MASK) == SOF3_PATTERN;
                                    end
                                    held       = bc2 - BC_W'(s);
                                    n_sof_eff  = s;
                                    n_sof_done = 1'b1;
                                    n_good     = good;
                                    n_bc       = held;
                                    // release the held bits past the start of frame
                                    for (int i = 0; i < MAX_BITS; i++) begin
                                        p = {1'b0, s} + 4'(i);
                                        rec.bits[i] = p[3] ? 1'b0 : shift2[~p[2:0]];
                                    end
                                    rec.nbits    = held[1:0];
                                    rec.base_idx = '0;
                                end
                            end
                        end
                        if (n_reject > i_cfg.error_limit) begin
                            n_done     = 1'b1;
                            rec.end_en = 1'b1;
                            rec.cause  = CAUSE_ERRORS;
                        end else if (n_bc[BC_W-1:3] >= i_cfg.buffer_bytes) begin
                            n_done     = 1'b1;
                            rec.end_en = 1'b1;
                            rec.cause  = CAUSE_FULL;
                        end
                    end
                end
                default: ;
            endcase
        end
        rec.end_idx = n_bc;
        rec.sof_ok  = n_sof_done && n_good;
        rec.err     = n_reject;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_done     <= 1'b0;
            r_prev     <= 1'b1;
            r_skip     <= 1'b1;
            r_sof_done <= 1'b0;
            r_good     <= 1'b0;
            r_shift    <= 8'h00;
            r_bc       <= '0;
            r_reject   <= '0;
            r_sof_eff  <= '0;
        end else begin
            r_started  <= n_started;
            r_done     <= n_done;
            r_prev     <= n_prev;
            r_skip     <= n_skip;
            r_sof_done <= n_sof_done;
            r_good     <= n_good;
            r_shift    <= n_shift;
            r_bc       <= n_bc;
            r_reject   <= n_reject;
            r_sof_eff  <= n_sof_eff;
        end
    end

    assign o_stall = i_full;
    assign o_push  = accept && (rec.start || (rec.nbits != 2'd0) || rec.end_en);
    assign o_rec   = rec;

endmodule

/* rtl/lftd_fifo.sv */
module lftd_fifo #(
    parameter int DEPTH = lftd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lftd_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output lftd_pkg::t_rec o_rec,
    output logic           o_empty
);
    import lftd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/lftd_back.sv */
module lftd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  lftd_pkg::t_rec               i_rec,
    output logic                         o_pop,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [lftd_pkg::KIND_W-1:0]  o_kind,
    output logic                         o_bit_value,
    output logic [lftd_pkg::BC_W-1:0]    o_bit_index,
    output logic                         o_sof_ok,
    output logic [lftd_pkg::CAUSE_W-1:0] o_end_cause,
    output logic [lftd_pkg::ERR_W-1:0]   o_error_count,
    output logic                         o_last
);
    import lftd_pkg::*;

    logic [1:0]         r_k;
    logic               r_valid;
    logic [KIND_W-1:0]  r_kind;
    logic               r_bit;
    logic [BC_W-1:0]    r_idx;
    logic               r_sof_ok;
    logic [CAUSE_W-1:0] r_cause;
    logic [ERR_W-1:0]   r_err;
    logic               r_last;

    logic [2:0]         total;
    logic               load, is_last;
    logic [KIND_W-1:0]  kind;
    logic               bit_val;
    logic [BC_W-1:0]    idx;
    logic [CAUSE_W-1:0] cause;

    assign total   = 3'(i_rec.start) + 3'(i_rec.nbits) + 3'(i_rec.end_en);
    assign is_last = ({1'b0, r_k} == (total - 3'd1));
    assign load    = !i_empty && (!r_valid || !i_stall);
    assign o_pop   = load && is_last;

    // r_k walks start, data bits, end of the head record
    always_comb begin
        kind    = KIND_END;
        bit_val = 1'b0;
        idx     = i_rec.end_idx;
        cause   = i_rec.cause;
        if (i_rec.start && (r_k == 2'd0)) begin
            kind  = KIND_START;
            idx   = '0;
            cause = CAUSE_NONE;
        end else if (!i_rec.start && (r_k < i_rec.nbits)) begin
            kind    = KIND_BIT;
            bit_val = i_rec.bits[r_k];
            idx     = i_rec.base_idx + BC_W'(r_k);
            cause   = CAUSE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= kind;
            r_bit    <= bit_val;
            r_idx    <= idx;
            r_sof_ok <= i_rec.sof_ok;
            r_cause  <= cause;
            r_err    <= i_rec.err;
            r_last   <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= is_last ? 2'd0 : r_k + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_bit_value   = r_bit;
    assign o_bit_index   = r_idx;
    assign o_sof_ok      = r_sof_ok;
    assign o_end_cause   = r_cause;
    assign o_error_count = r_err;
    assign o_last        = r_last;

endmodule

/* rtl/lf_tag_response_edge_decoder_unit.sv */
// Edge-interval decoder for a low-frequency tag response.
// Input channel (i_valid / o_stall): one command per transfer; arm, a
//   falling-edge interval in carrier periods, or a silence timeout.
// Output channel (o_valid / i_stall): one result per transfer; frame start,
//   data bit, or frame end, with o_last on the final result of an input.
// Config channel (i_cfg_valid / o_cfg_ready): register index and data,
//   always ready; write only while the decoder is idle.
// Each input's record is written into the queue; its first result is then
//   loaded into the output register.
// The front classifies one input per cycle into a record queue while the
//   queue is not full; the back drains one result per cycle while i_stall is
//   low, one at a time through the single output register.
// Reset: registers take their default values, the decoder behaves as armed
//   with no start-of-frame bits, the queue and output register empty.
// A stalled output holds its result; the queue then fills and o_stall rises.
module lf_tag_response_edge_decoder_unit #(
    parameter int INTERVAL_WIDTH = lftd_pkg::INTERVAL_WIDTH_DEF,
    parameter int QUEUE_DEPTH    = lftd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [lftd_pkg::CMD_W-1:0]      i_cmd,
    input  logic [lftd_pkg::IV_W-1:0]       i_interval,
    // output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [lftd_pkg::KIND_W-1:0]     o_kind,
    output logic                            o_bit_value,
    output logic [lftd_pkg::BC_W-1:0]       o_bit_index,
    output logic                            o_sof_ok,
    output logic [lftd_pkg::CAUSE_W-1:0]    o_end_cause,
    output logic [lftd_pkg::ERR_W-1:0]      o_error_count,
    output logic                            o_last,
    // config channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lftd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lftd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lftd_pkg::*;

    t_cfg r_cfg;
    logic cfg_we;

    logic q_push, q_full, q_pop, q_empty;
    t_rec q_in, q_out;

    // register file; writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coding_mode  <= RST_CODING_MODE;
            r_cfg.sof_length   <= RST_SOF_LENGTH;
            r_cfg.start_th     <= RST_START_TH;
            r_cfg.two_th       <= RST_TWO_TH;
            r_cfg.three_th     <= RST_THREE_TH;
            r_cfg.four_th      <= RST_FOUR_TH;
            r_cfg.buffer_bytes <= RST_BUF_BYTES;
            r_cfg.error_limit  <= RST_ERR_LIMIT;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_CODING_MODE: r_cfg.coding_mode  <= i_cfg_data[MODE_W-1:0];
                REG_SOF_LENGTH:  r_cfg.sof_length   <= i_cfg_data[SOFL_W-1:0];
                REG_START_TH:    r_cfg.start_th     <= i_cfg_data[TH_W-1:0];
                REG_TWO_TH:      r_cfg.two_th       <= i_cfg_data[TH_W-1:0];
                REG_THREE_TH:    r_cfg.three_th     <= i_cfg_data[TH_W-1:0];
                REG_FOUR_TH:     r_cfg.four_th      <= i_cfg_data[TH_W-1:0];
                REG_BUF_BYTES:   r_cfg.buffer_bytes <= i_cfg_data[BYTES_W-1:0];
                REG_ERR_LIMIT:   r_cfg.error_limit  <= i_cfg_data[ERR_W-1:0];
                default: ;
            endcase
        end
    end

    // front: frame state and classification, at most one record per input
    lftd_front #(
        .INTERVAL_WIDTH(INTERVAL_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .i_cmd      (i_cmd),
        .i_interval (i_interval),
        .o_stall    (o_stall),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_rec      (q_in)
    );

    // record queue decouples classification from result delivery
    lftd_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rec   (q_out),
        .o_empty (q_empty)
    );

    // back: serializes each record into individual results
    lftd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_rec         (q_out),
        .o_pop         (q_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_bit_value   (o_bit_value),
        .o_bit_index   (o_bit_index),
        .o_sof_ok      (o_sof_ok),
        .o_end_cause   (o_end_cause),
        .o_error_count (o_error_count),
        .o_last        (o_last)
    );

endmodule
